/* rtl/sscr_pkg.sv */
// ----------------------------------------------------------------------------
// Strip chart renderer package
// Shared sizes and defaults for the scrolling strip chart renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package sscr_pkg;

  localparam int CHART_WIDTH  = 256;
  localparam int CHART_HEIGHT = 128;
  localparam int SAMPLE_W     = 31;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_READ = 1'b1;

endpackage

`default_nettype wire

/* rtl/sscr_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sscr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/scrolling_strip_chart_renderer.sv */
// ----------------------------------------------------------------------------
// Scrolling strip chart renderer
// Draws a rolling line chart into a one-bit frame and serves pixel reads.
// ----------------------------------------------------------------------------
// Usage: a request on the input channel either pushes a sample (req_type_i 0)
// or reads one pixel (req_type_i 1). Every request gives exactly one result
// on the output channel with the pixel, the running peak and the rescale flag.
// Each frame column holds a single vertical run, so the frame is kept as one
// lo/hi height pair per column in a RAM, addressed circularly so a scroll is
// just a base pointer step. The sample window is a second circular RAM.
// Heights come from one shared multiply and a restoring divider that gives
// one quotient bit per cycle, HW = clog2(CHART_HEIGHT+1) bits per column; each
// column steps through read, multiply, divide and write states.
// A pixel read steps through read, check and result states. A push without
// a new peak works through the last two columns; one that raises it, all of them.
// One request is worked on at a time; the next is taken once the result sits
// in the output register, even while the receiver stalls it.
// After reset the frame is blank, the window is zero and the peak is one; no
// clearing pass is needed since fill counts mark the columns never written.
// ----------------------------------------------------------------------------
`default_nettype none

module scrolling_strip_chart_renderer #(
  parameter int CHART_WIDTH  = sscr_pkg::CHART_WIDTH,
  parameter int CHART_HEIGHT = sscr_pkg::CHART_HEIGHT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        req_type_i,
  input  wire logic [31:0] sample_value_i,
  input  wire logic [7:0]  read_x_i,
  input  wire logic [6:0]  read_y_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             pixel_on_o,
  output logic [30:0]      peak_now_o,
  output logic             rescaled_o
);

  localparam int SW = sscr_pkg::SAMPLE_W;
  localparam int XW = $clog2(CHART_WIDTH);
  localparam int HW = $clog2(CHART_HEIGHT + 1);
  localparam int PW = SW + HW;
  localparam int CW = $clog2(HW);
  localparam int FW = 2 * HW;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_PIX_RD  = 8'b0000_0010,
    ST_PIX_CHK = 8'b0000_0100,
    ST_COL_RD  = 8'b0000_1000,
    ST_MUL     = 8'b0001_0000,
    ST_DIV     = 8'b0010_0000,
    ST_COL_WR  = 8'b0100_0000,
    ST_RESULT  = 8'b1000_0000
  } state_e;

  state_e          state_q, state_d;
  logic [SW-1:0]   peak_q, peak_d;
  logic [XW-1:0]   base_q, base_d;
  logic [XW:0]     wfill_q, wfill_d;
  logic [XW:0]     ffill_q, ffill_d;
  logic [XW-1:0]   col_q, col_d;
  logic            rise_q, rise_d;
  logic            vld_q, vld_d;
  logic [HW-1:0]   hprev_q, hprev_d;
  logic [PW-1:0]   rem_q, rem_d;
  logic [PW-1:0]   dsr_q, dsr_d;
  logic [HW-1:0]   quo_q, quo_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [XW-1:0]   px_q, px_d;
  logic [HW-1:0]   py_q, py_d;
  logic            pix_q, pix_d;
  logic            out_valid_q, out_valid_d;
  logic            out_pix_q, out_pix_d;
  logic [SW-1:0]   out_peak_q, out_peak_d;
  logic            out_resc_q, out_resc_d;

  logic            accept;
  logic [SW-1:0]   sample_clamped;
  logic            win_we;
  logic [XW-1:0]   win_raddr;
  logic [SW-1:0]   win_rdata;
  logic            frm_we;
  logic [XW-1:0]   frm_waddr;
  logic [FW-1:0]   frm_wdata;
  logic [XW-1:0]   frm_raddr;
  logic [FW-1:0]   frm_rdata;
  logic [HW-1:0]   frm_lo, frm_hi, pix_h;
  logic [31:0]     x_sat, y_sat;
  logic [SW-1:0]   mul_val;
  logic            rem_ge;

  function automatic logic [XW-1:0] phys_col(input logic [XW-1:0] base,
                                             input logic [XW-1:0] x);
    logic [XW:0] s;
    s = {1'b0, base} + {1'b0, x};
    if (s >= (XW+1)'(CHART_WIDTH)) begin
      s = s - (XW+1)'(CHART_WIDTH);
    end
    return s[XW-1:0];
  endfunction

  assign in_stall_o     = (state_q != ST_IDLE);
  assign accept         = in_valid_i && !in_stall_o;
  assign sample_clamped = sample_value_i[31] ? '0 : sample_value_i[SW-1:0];

  assign win_we    = accept && (req_type_i == sscr_pkg::REQ_PUSH);
  assign win_raddr = phys_col(base_q, col_q);
  assign frm_raddr = phys_col(base_q, px_q);
  assign frm_waddr = phys_col(base_q, col_q);
  assign frm_we    = (state_q == ST_COL_WR) && (rise_q || col_q == XW'(CHART_WIDTH - 1));
  assign frm_wdata = (hprev_q < quo_q) ? {hprev_q, quo_q} : {quo_q, hprev_q};
  assign frm_lo    = frm_rdata[FW-1:HW];
  assign frm_hi    = frm_rdata[HW-1:0];
  assign pix_h     = HW'(CHART_HEIGHT - 1) - py_q;

  assign x_sat = ({24'd0, read_x_i} >= 32'(CHART_WIDTH)) ? 32'(CHART_WIDTH - 1)
                                                          : {24'd0, read_x_i};
  assign y_sat = ({25'd0, read_y_i} >= 32'(CHART_HEIGHT)) ? 32'(CHART_HEIGHT - 1)
                                                           : {25'd0, read_y_i};

  assign mul_val = vld_q ? win_rdata : '0;
  assign rem_ge  = (rem_q >= dsr_q);

  sscr_ram #(
    .WIDTH (SW),
    .DEPTH (CHART_WIDTH)
  ) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (base_q),
    .wdata_i (sample_clamped),
    .raddr_i (win_raddr),
    .rdata_o (win_rdata)
  );

  sscr_ram #(
    .WIDTH (FW),
    .DEPTH (CHART_WIDTH)
  ) u_frm_ram (
    .clk_i   (clk_i),
    .we_i    (frm_we),
    .waddr_i (frm_waddr),
    .wdata_i (frm_wdata),
    .raddr_i (frm_raddr),
    .rdata_o (frm_rdata)
  );

  always_comb begin
    state_d     = state_q;
    peak_d      = peak_q;
    base_d      = base_q;
    wfill_d     = wfill_q;
    ffill_d     = ffill_q;
    col_d       = col_q;
    rise_d      = rise_q;
    vld_d       = vld_q;
    hprev_d     = hprev_q;
    rem_d       = rem_q;
    dsr_d       = dsr_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    px_d        = px_q;
    py_d        = py_q;
    pix_d       = pix_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_pix_d   = out_pix_q;
    out_peak_d  = out_peak_q;
    out_resc_d  = out_resc_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == sscr_pkg::REQ_READ) begin
            px_d    = x_sat[XW-1:0];
            py_d    = y_sat[HW-1:0];
            rise_d  = 1'b0;
            state_d = ST_PIX_RD;
          end else begin
            base_d  = (base_q == XW'(CHART_WIDTH - 1)) ? '0 : base_q + XW'(1);
            wfill_d = (wfill_q == (XW+1)'(CHART_WIDTH)) ? wfill_q : wfill_q + (XW+1)'(1);
            rise_d  = (sample_clamped > peak_q);
            hprev_d = '0;
            if (sample_clamped > peak_q) begin
              peak_d  = sample_clamped;
              ffill_d = (XW+1)'(CHART_WIDTH);
              col_d   = '0;
            end else begin
              ffill_d = (ffill_q == (XW+1)'(CHART_WIDTH)) ? ffill_q
                                                           : ffill_q + (XW+1)'(1);
              col_d   = XW'(CHART_WIDTH - 2);
            end
            state_d = ST_COL_RD;
          end
        end
      end
      ST_PIX_RD: begin
        vld_d   = ({1'b0, px_q} + ffill_q) >= (XW+1)'(CHART_WIDTH);
        state_d = ST_PIX_CHK;
      end
      ST_PIX_CHK: begin
        if (py_q == '0) begin
          pix_d = vld_q && (frm_hi >= HW'(CHART_HEIGHT - 1));
        end else begin
          pix_d = vld_q && (frm_lo <= pix_h) && (pix_h <= frm_hi);
        end
        state_d = ST_RESULT;
      end
      ST_COL_RD: begin
        vld_d   = ({1'b0, col_q} + wfill_q) >= (XW+1)'(CHART_WIDTH);
        state_d = ST_MUL;
      end
      ST_MUL: begin
        rem_d   = PW'(mul_val) * PW'(CHART_HEIGHT);
        dsr_d   = PW'(peak_q) << (HW - 1);
        quo_d   = '0;
        cnt_d   = CW'(HW - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (rem_ge) begin
          rem_d = rem_q - dsr_q;
        end
        quo_d = {quo_q[HW-2:0], rem_ge};
        dsr_d = dsr_q >> 1;
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          state_d = ST_COL_WR;
        end
      end
      ST_COL_WR: begin
        hprev_d = quo_q;
        if (col_q == XW'(CHART_WIDTH - 1)) begin
          pix_d   = 1'b0;
          state_d = ST_RESULT;
        end else begin
          col_d   = col_q + XW'(1);
          state_d = ST_COL_RD;
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_pix_d   = pix_q;
          out_peak_d  = peak_q;
          out_resc_d  = rise_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      peak_q      <= SW'(1);
      base_q      <= '0;
      wfill_q     <= '0;
      ffill_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      peak_q      <= peak_d;
      base_q      <= base_d;
      wfill_q     <= wfill_d;
      ffill_q     <= ffill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q      <= col_d;
    rise_q     <= rise_d;
    vld_q      <= vld_d;
    hprev_q    <= hprev_d;
    rem_q      <= rem_d;
    dsr_q      <= dsr_d;
    quo_q      <= quo_d;
    cnt_q      <= cnt_d;
    px_q       <= px_d;
    py_q       <= py_d;
    pix_q      <= pix_d;
    out_pix_q  <= out_pix_d;
    out_peak_q <= out_peak_d;
    out_resc_q <= out_resc_d;
  end

  assign out_valid_o = out_valid_q;
  assign pixel_on_o  = out_pix_q;
  assign peak_now_o  = out_peak_q;
  assign rescaled_o  = out_resc_q;

  // A taken request always moves the sequencer out of idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_IDLE))
    else $error("request taken but sequencer stayed idle");

  // The scaling divisor can never become zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q != '0)
    else $error("running peak reached zero");

  // Fill counts never pass the chart width.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wfill_q <= (XW+1)'(CHART_WIDTH)) && (ffill_q <= (XW+1)'(CHART_WIDTH)))
    else $error("fill count beyond chart width");

  // A new result is loaded only from the result state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_d && !(out_valid_q && out_stall_i)) |-> (state_q == ST_RESULT))
    else $error("result loaded outside result state");

endmodule

`default_nettype wire
